[design/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// Block allocator package
// Shared constants and opcode/status codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int MAX_BLOCKS_DEF    = 256;
  localparam int MAP_WORD_BITS_DEF = 8;

  localparam int BS_W  = 13;
  localparam int CNT_W = 9;
  localparam int REQ_W = 21;
  localparam int OFF_W = 20;
  localparam int DIV_W = 21;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOROOM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [BS_W-1:0]  BS_RESET  = 13'd64;
  localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

  // Command to the shared divider.
  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [BS_W-1:0]  divisor;
  } div_req_t;

endpackage

[design/bitmap_first_fit_block_allocator.sv]
// An allocate runs a divide and a bitmap scan and mark, a free runs two divides
// and clears its blocks, a query checks the offset and a rejected item goes
// straight to the result strobe. Throughput: one item at a time.
// Run time: bit-serial divider plus a one-block-per-cycle bitmap walk.
// Synchronous active-low reset clears the bitmap and loads register defaults.
// The receiver cannot stall; out_valid pulses for one cycle per item.
// ----------------------------------------------------------------------------
// First-fit block allocator top level
// Keeps a block occupancy bitmap and serves allocate, free and query items.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator import bffa_pkg::*; #(
  parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_opcode,
  input  logic [REQ_W-1:0] in_request_bytes,
  input  logic [OFF_W-1:0] in_pool_offset,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [OFF_W-1:0] out_granted_offset,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [BS_W-1:0]  cfg_wdata
);

  localparam int BW = $clog2(MAX_BLOCKS + 1) + 1;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int WB = $clog2(MAP_WORD_BITS);
  localparam int MAP_WORDS = MAX_BLOCKS / MAP_WORD_BITS;
  localparam int PW = BW + BS_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVN  = 4'd1;
  localparam logic [3:0] S_DIVF  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_MARK  = 4'd5;
  localparam logic [3:0] S_CLR   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_QRY   = 4'd8;
  localparam logic [3:0] S_WDIV  = 4'd9;

  logic [BS_W-1:0]  bs_r;
  logic [CNT_W-1:0] cnt_cfg_r;
  logic [3:0]       st_r;
  logic [1:0]       op_r;
  logic [REQ_W-1:0] bytes_r;
  logic [OFF_W-1:0] off_r;
  logic [MAP_WORD_BITS-1:0] map_r [MAP_WORDS];
  logic [BW-1:0]    n_r, first_r, b_r, run_r, start_r, last_r;
  logic [1:0]       status_r;
  logic [OFF_W-1:0] grant_r;
  logic             ovf_r;
  logic [3:0]       ret_r;
  logic             vld_r;
  logic [BS_W-1:0]  bse;
  logic [BW-1:0]    cnte;
  div_req_t         dreq;
  logic             ddone;
  logic [DIV_W-1:0] dquot;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    pool_bytes;
  logic [IW-1:0]    bi;
  logic [IW-WB-1:0] wsel;
  logic [WB-1:0]    bsel;

  assign bse  = (bs_r == '0) ? BS_W'(1) : bs_r;
  assign cnte = (BW'(cnt_cfg_r) > BW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(cnt_cfg_r);
  assign bi   = b_r[IW-1:0];
  // The most significant bit of a word holds the lowest block in it.
  assign wsel = bi[IW-1:WB];
  assign bsel = ~bi[WB-1:0];
  assign prod = PW'(start_r) * PW'(bse);
  assign pool_bytes = PW'(cnte) * PW'(bse);

  bffa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

  // Divider commands from the sequencer.
  always_comb begin
    dreq.go       = 1'b0;
    dreq.dividend = DIV_W'(bytes_r - 1'b1);
    dreq.divisor  = bse;
    if (st_r == S_DIVN) begin
      dreq.go = 1'b1;
    end else if (st_r == S_DIVF) begin
      dreq.go = 1'b1;
      dreq.dividend = DIV_W'(off_r);
    end
  end

  // Sequencer: one block per cycle for scan, mark and clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      map_r     <= '{default: '0};
      bs_r      <= BS_RESET;
      cnt_cfg_r <= CNT_RESET;
      vld_r     <= 1'b0;
    end else begin
      vld_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == 1'b0) bs_r <= cfg_wdata;
        else cnt_cfg_r <= cfg_wdata[CNT_W-1:0];
      end
      case (st_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_opcode;
            bytes_r <= in_request_bytes;
            off_r   <= in_pool_offset;
            grant_r <= '0;
            status_r <= ST_BAD;
            if ((in_opcode inside {OP_ALLOC, OP_FREE}) && in_request_bytes != '0)
              st_r <= S_DIVN;
            else if (in_opcode == OP_QUERY)
              st_r <= S_QRY;
            else
              st_r <= S_DONE;
          end
        end
        S_DIVN: begin
          ret_r <= (op_r == OP_ALLOC) ? S_SCAN : S_DIVF;
          st_r  <= S_WDIV;
        end
        S_WDIV: begin
          if (ddone) begin
            if (ret_r inside {S_SCAN, S_DIVF}) begin
              n_r <= (dquot >= DIV_W'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS + 1)
                                                   : BW'(dquot + 1'b1);
              b_r <= '0;
              run_r <= '0;
              status_r <= ST_NOROOM;
              st_r <= ret_r;
            end else begin
              first_r <= (dquot >= DIV_W'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(dquot);
              b_r <= (dquot >= DIV_W'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(dquot);
              ovf_r <= (BW+1)'(dquot >= DIV_W'(MAX_BLOCKS) ? MAX_BLOCKS : dquot)
                       + (BW+1)'(n_r) > (BW+1)'(cnte);
              st_r <= S_CLR;
            end
          end
        end
        S_DIVF: begin
          ret_r <= S_CLR;
          st_r  <= S_WDIV;
        end
        S_SCAN: begin
          if (b_r >= cnte) begin
            st_r <= S_DONE;
          end else if (map_r[wsel][bsel]) begin
            run_r <= '0;
            b_r   <= b_r + 1'b1;
          end else if (run_r + 1'b1 == n_r) begin
            start_r <= b_r + 1'b1 - n_r;
            st_r    <= S_MUL;
          end else begin
            run_r <= run_r + 1'b1;
            b_r   <= b_r + 1'b1;
          end
        end
        S_MUL: begin
          if (prod <= PW'({OFF_W{1'b1}})) begin
            grant_r  <= prod[OFF_W-1:0];
            status_r <= ST_OK;
            b_r      <= start_r;
            last_r   <= start_r + n_r;
            st_r     <= S_MARK;
          end else begin
            st_r <= S_DONE;
          end
        end
        S_MARK: begin
          if (b_r >= last_r) st_r <= S_DONE;
          else begin
            map_r[wsel][bsel] <= 1'b1;
            b_r <= b_r + 1'b1;
          end
        end
        S_CLR: begin
          status_r <= ovf_r ? ST_BAD : ST_OK;
          if ((BW+1)'(b_r) >= (BW+1)'(first_r) + (BW+1)'(n_r) || b_r >= cnte)
            st_r <= S_DONE;
          else begin
            map_r[wsel][bsel] <= 1'b0;
            b_r <= b_r + 1'b1;
          end
        end
        S_QRY: begin
          status_r <= (PW'(off_r) < pool_bytes) ? ST_OK : ST_BAD;
          st_r <= S_DONE;
        end
        S_DONE: begin
          vld_r <= 1'b1;
          st_r  <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (st_r != S_IDLE);
  assign out_valid          = vld_r;
  assign out_status         = status_r;
  assign out_granted_offset = grant_r;

endmodule

[design/bffa_div.sv]
// ----------------------------------------------------------------------------
// Block allocator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bffa_div import bffa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [BS_W-1:0]  rem_r, rem_nxt;
  logic [BS_W-1:0]  dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BS_W:0]    trial;

  // One shift-subtract step per cycle.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[DIV_W-1]};
    if (req.go) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = BS_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BS_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (req.go) dvs_r <= req.divisor;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
